[sv/obd_hex_response_parser_unit_assert.svh]
// Assertion macros used by the checker file of this block.
`ifndef OBD_HEX_RESPONSE_PARSER_UNIT_ASSERT_SVH
`define OBD_HEX_RESPONSE_PARSER_UNIT_ASSERT_SVH

// Concurrent check, masked while reset is high.
`define OHRP_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent check that also holds during reset.
`define OHRP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[sv/ohrp_pkg.sv]
package ohrp_pkg;

  localparam int MAX_BYTES_DEF = 4;

  localparam int VALUE_W = 32;
  localparam int BCNT_W  = 3;

  localparam logic [BCNT_W-1:0] BCNT_RESET = BCNT_W'(1);

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UF    = 8'h46;
  localparam logic [7:0] CH_D0    = 8'h30;
  localparam logic [7:0] CH_D9    = 8'h39;

  typedef enum logic [2:0] {
    PH_SKIP1 = 3'd0,
    PH_SKIP2 = 3'd1,
    PH_HI    = 3'd2,
    PH_LO    = 3'd3,
    PH_SEP   = 3'd4,
    PH_WAIT  = 3'd5
  } phase_t;

  typedef struct packed {
    logic ok;
    logic [3:0] digit;
  } hex_dig_t;

  // Result offered by the parser core for the byte being processed.
  typedef struct packed {
    logic emit;
    logic [VALUE_W-1:0] value;
    logic bad_digit;
  } ohrp_res_t;

  // Uppercase hex only; anything else decodes to zero and flags an error.
  function automatic hex_dig_t hex_decode(input logic [7:0] c);
    hex_dig_t r;
    r.ok    = 1'b1;
    r.digit = 4'd0;
    if (c >= CH_UA && c <= CH_UF) begin
      r.digit = 4'(c - CH_UA + 8'd10);
    end else if (c >= CH_D0 && c <= CH_D9) begin
      r.digit = 4'(c - CH_D0);
    end else begin
      r.ok = 1'b0;
    end
    return r;
  endfunction

endpackage

[sv/ohrp_core.sv]
module ohrp_core
  import ohrp_pkg::*;
#(
  parameter int MAX_BYTES = MAX_BYTES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic [7:0]        ch,
  input  logic [BCNT_W-1:0] byte_count,
  output ohrp_res_t         res
);

  localparam int PW = $clog2(MAX_BYTES + 1);
  localparam logic [3:0] MaxB = 4'(MAX_BYTES);

  phase_t              phase, phase_next;
  logic [PW-1:0]       pairs_done, pairs_done_next;
  logic [VALUE_W-1:0]  accumulator, accumulator_next;
  logic                error_seen, error_seen_next;

  logic [3:0]  bc_wide;
  logic [3:0]  expected;
  logic [3:0]  pairs_inc;
  hex_dig_t    dig;

  assign bc_wide   = {1'b0, byte_count};
  assign expected  = (bc_wide > MaxB) ? MaxB : bc_wide;
  assign pairs_inc = 4'(pairs_done) + 4'd1;
  assign dig       = hex_decode(ch);

  always_comb begin
    phase_next       = phase;
    pairs_done_next  = pairs_done;
    accumulator_next = accumulator;
    error_seen_next  = error_seen;
    res.emit         = 1'b0;
    res.value        = error_seen ? '0 : accumulator;
    res.bad_digit    = error_seen;
    unique case (phase) inside
      PH_SKIP1: begin
        if (ch == CH_SPACE) phase_next = PH_SKIP2;
      end
      PH_SKIP2: begin
        if (ch == CH_SPACE) phase_next = (expected == 4'd0) ? PH_WAIT : PH_HI;
      end
      PH_HI, PH_LO: begin
        accumulator_next = {accumulator[VALUE_W-5:0], dig.digit};
        error_seen_next  = error_seen | ~dig.ok;
        phase_next       = (phase == PH_HI) ? PH_LO : PH_SEP;
      end
      PH_SEP: begin
        // separator byte is dropped unchecked
        pairs_done_next = PW'(pairs_inc);
        phase_next      = (pairs_inc >= expected) ? PH_WAIT : PH_HI;
      end
      PH_WAIT: begin
        if (ch == CH_GT) begin
          res.emit         = 1'b1;
          phase_next       = PH_SKIP1;
          pairs_done_next  = '0;
          accumulator_next = '0;
          error_seen_next  = 1'b0;
        end
      end
      default: begin
        phase_next       = PH_SKIP1;
        pairs_done_next  = '0;
        accumulator_next = '0;
        error_seen_next  = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_SKIP1;
      pairs_done  <= '0;
      accumulator <= '0;
      error_seen  <= 1'b0;
    end else if (step) begin
      phase       <= phase_next;
      pairs_done  <= pairs_done_next;
      accumulator <= accumulator_next;
      error_seen  <= error_seen_next;
    end
  end

endmodule

[sv/obd_hex_response_parser_unit.sv]
// Channel  | Handshake               | Payload
// ---------+-------------------------+--------------------------------
// input    | in_valid / in_ready     | rx_byte[7:0]
// output   | out_valid / out_ready   | value[31:0], bad_digit
// config   | cfg_valid / cfg_ready   | byte_count[2:0]
//
// One received character per cycle sustained while the output is not
// stalled. A character is held and parsed in the input register, and
// its result (only on the closing '>') lands in the output register as
// the character is consumed. Synchronous active-high reset; byte_count
// resets to 1, the parser to its first-space search. An output stall
// holds the result and backs up the input register; in_ready stays
// high whenever the output register is empty or being drained.
module obd_hex_response_parser_unit
  import ohrp_pkg::*;
#(
  parameter int MAX_BYTES = MAX_BYTES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  // received characters
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         rx_byte,
  // parsed replies
  output logic               out_valid,
  input  logic               out_ready,
  output logic [VALUE_W-1:0] value,
  output logic               bad_digit,
  // byte count register
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [BCNT_W-1:0]  byte_count
);

  // input register
  logic       stg_valid, stg_valid_next;
  logic [7:0] stg_byte;
  logic       stg_fire;

  // config register
  logic [BCNT_W-1:0] bcnt;

  // parser core result for the staged character
  ohrp_res_t res;

  logic out_valid_next;

  // The staged character is parsed once the output register can take a
  // result, so a result is never dropped.
  assign stg_fire  = stg_valid & (~out_valid | out_ready);
  assign in_ready  = ~stg_valid | stg_fire;
  assign cfg_ready = 1'b1;

  assign stg_valid_next = (in_valid & in_ready) | (stg_valid & ~stg_fire);
  assign out_valid_next = stg_fire ? res.emit : (out_valid & ~out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid <= 1'b0;
      out_valid <= 1'b0;
      bcnt      <= BCNT_RESET;
    end else begin
      stg_valid <= stg_valid_next;
      out_valid <= out_valid_next;
      if (cfg_valid & cfg_ready) bcnt <= byte_count;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    if (in_valid & in_ready) stg_byte <= rx_byte;
    if (stg_fire & res.emit) begin
      value     <= res.value;
      bad_digit <= res.bad_digit;
    end
  end

  ohrp_core #(
    .MAX_BYTES (MAX_BYTES)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .step       (stg_fire),
    .ch         (stg_byte),
    .byte_count (bcnt),
    .res        (res)
  );

endmodule

[sv/ohrp_checker.sv]
`include "obd_hex_response_parser_unit_assert.svh"

module ohrp_checker
  import ohrp_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [VALUE_W-1:0] value,
  input logic               bad_digit
);

  // stalled result holds
  `OHRP_ASSERT(a_out_hold, clk, rst, out_valid && !out_ready |=> out_valid && $stable(value) && $stable(bad_digit), "output changed while stalled")
  // a flagged reply carries a zero value
  `OHRP_ASSERT(a_bad_zero, clk, rst, out_valid && bad_digit |-> value == '0, "bad reply with nonzero value")
  // empty output register never back-pressures the input
  `OHRP_ASSERT(a_in_open, clk, rst, !out_valid |-> in_ready, "input stalled with empty output")
  // reset empties the output register
  `OHRP_ASSERT_ALWAYS(a_rst_out, clk, rst |=> !out_valid, "output valid after reset")

endmodule

bind obd_hex_response_parser_unit ohrp_checker u_ohrp_checker (.*);
